FILE: rtl/isocc_pkg.sv
// Shared types and constants for the isoline cell crossing block.
`timescale 1ns / 1ps
package isocc_pkg;

  localparam int unsigned Corners = 4;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW = 16;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned QuoW = CoordW;
  localparam int unsigned DivLat = QuoW + 4;
  localparam int unsigned CntW = 4;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic RegLevel = 1'b0;
  localparam logic RegTol = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner0_z;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner1_z;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner2_z;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
    logic signed [CoordW-1:0] corner3_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     run_is_strip;
    logic                     last_point;
  } out_word_t;

  typedef struct packed {
    logic [Corners-1:0]             hit;
    logic [Corners-1:0]             flat;
    logic [Corners-1:0][CoordW-1:0] x;
    logic [Corners-1:0][CoordW-1:0] y;
  } side_t;

endpackage

FILE: rtl/isocc_divpipe.sv
// Pipelined scaled offset trunc(n * dv / d), one quotient bit per stage.
`timescale 1ns / 1ps
module isocc_divpipe
  import isocc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [DiffW-1:0] n_i,
  input  logic signed [DiffW-1:0] dv_i,
  input  logic signed [DiffW-1:0] d_i,
  output logic signed [DiffW-1:0] off_o
);

  logic signed [DiffW-1:0] n_q, dv_q, d_q;
  logic [CoordW-1:0] a_d, b_d, dm_d;
  logic [CoordW-1:0] a_q, b_q, dm1_q;
  logic neg_d, neg1_q;
  logic [2*CoordW-1:0] prod_q;
  logic [CoordW-1:0] dm2_q;
  logic neg2_q;
  logic [CoordW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [CoordW-1:0] low_q [QuoW];
  logic [CoordW-1:0] dmk_q [QuoW];
  logic negk_q [QuoW];
  logic signed [DiffW-1:0] off_d, off_q;
  logic [DiffW-1:0] n_abs, dv_abs, d_abs;

  assign n_abs  = n_q[DiffW-1] ? DiffW'(-n_q) : DiffW'(n_q);
  assign dv_abs = dv_q[DiffW-1] ? DiffW'(-dv_q) : DiffW'(dv_q);
  assign d_abs  = d_q[DiffW-1] ? DiffW'(-d_q) : DiffW'(d_q);
  assign a_d    = n_abs[CoordW-1:0];
  assign b_d    = dv_abs[CoordW-1:0];
  assign dm_d   = d_abs[CoordW-1:0];
  assign neg_d  = n_q[DiffW-1] ^ dv_q[DiffW-1] ^ d_q[DiffW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_i;
      dv_q   <= dv_i;
      d_q    <= d_i;
      a_q    <= a_d;
      b_q    <= b_d;
      dm1_q  <= dm_d;
      neg1_q <= neg_d;
      prod_q <= a_q * b_q;
      dm2_q  <= dm1_q;
      neg2_q <= neg1_q;
      off_q  <= off_d;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [CoordW-1:0] rem_in, low_in, dm_in, rem_d;
    logic [QuoW-1:0] quo_in;
    logic neg_in, qbit;
    logic [CoordW:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = prod_q[2*CoordW-1:CoordW];
      assign low_in = prod_q[CoordW-1:0];
      assign quo_in = '0;
      assign dm_in  = dm2_q;
      assign neg_in = neg2_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dm_in  = dmk_q[k-1];
      assign neg_in = negk_q[k-1];
    end

    assign trial = {rem_in, low_in[CoordW-1]};
    assign qbit  = trial >= {1'b0, dm_in};
    assign rem_d = qbit ? CoordW'(trial - {1'b0, dm_in}) : trial[CoordW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= {low_in[CoordW-2:0], 1'b0};
        quo_q[k]  <= {quo_in[QuoW-2:0], qbit};
        dmk_q[k]  <= dm_in;
        negk_q[k] <= neg_in;
      end
    end
  end

  assign off_d = negk_q[QuoW-1] ? DiffW'(-{1'b0, quo_q[QuoW-1]})
                                : DiffW'({1'b0, quo_q[QuoW-1]});
  assign off_o = off_q;

endmodule

FILE: rtl/isoline_cell_crossings.sv
// Top level: contour crossings of one grid cell, pipelined, with APB registers.
`timescale 1ns / 1ps
// Path from an accepted cell to its first point: input register, 36-stage
// multiply and bit-per-stage divide, result register.
// Throughput: one cell may enter every cycle while in_stall_o is low; the
// single output port emits one point per cycle while out_stall_i is low.
// Reset: pipeline and output empty, contour_level 0, flat_tolerance 1.
module isoline_cell_crossings
  import isocc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic signed [CoordW-1:0] level_q;
  logic [TolW-1:0] tol_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      tol_q   <= TolW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegLevel: level_q <= pwdata[CoordW-1:0];
        RegTol:   tol_q   <= pwdata[TolW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegLevel: prdata = level_q;
      RegTol:   prdata = ApbDataW'(tol_q);
      default:  prdata = '0;
    endcase
  end

  logic adv, ser_free, fin_vld, out_acc, cur_last;
  logic s0_vld_q;
  in_word_t s0_q;

  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= in_word_i;
    end
  end

  logic signed [CoordW-1:0] cx [Corners];
  logic signed [CoordW-1:0] cy [Corners];
  logic signed [CoordW-1:0] cz [Corners];
  side_t side_d;
  logic signed [DiffW-1:0] offx [Corners];
  logic signed [DiffW-1:0] offy [Corners];

  assign cx[0] = s0_q.corner0_x;
  assign cy[0] = s0_q.corner0_y;
  assign cz[0] = s0_q.corner0_z;
  assign cx[1] = s0_q.corner1_x;
  assign cy[1] = s0_q.corner1_y;
  assign cz[1] = s0_q.corner1_z;
  assign cx[2] = s0_q.corner2_x;
  assign cy[2] = s0_q.corner2_y;
  assign cz[2] = s0_q.corner2_z;
  assign cx[3] = s0_q.corner3_x;
  assign cy[3] = s0_q.corner3_y;
  assign cz[3] = s0_q.corner3_z;

  for (genvar m = 0; m < Corners; m++) begin : g_edge
    localparam int unsigned E = (m + 1) % Corners;
    logic signed [DiffW-1:0] d, n, dvx, dvy;
    logic [DiffW-1:0] ad;

    assign d   = DiffW'({cz[E][CoordW-1], cz[E]} - {cz[m][CoordW-1], cz[m]});
    assign n   = DiffW'({level_q[CoordW-1], level_q} - {cz[m][CoordW-1], cz[m]});
    assign dvx = DiffW'({cx[E][CoordW-1], cx[E]} - {cx[m][CoordW-1], cx[m]});
    assign dvy = DiffW'({cy[E][CoordW-1], cy[E]} - {cy[m][CoordW-1], cy[m]});
    assign ad  = (cz[E] >= cz[m]) ? DiffW'({cz[E][CoordW-1], cz[E]} - {cz[m][CoordW-1], cz[m]})
                                  : DiffW'({cz[m][CoordW-1], cz[m]} - {cz[E][CoordW-1], cz[E]});

    assign side_d.hit[m]  = (level_q >= cz[m] && level_q <= cz[E]) ||
                            (level_q >= cz[E] && level_q <= cz[m]);
    assign side_d.flat[m] = ad <= DiffW'(tol_q);
    assign side_d.x[m]    = cx[m];
    assign side_d.y[m]    = cy[m];

    isocc_divpipe u_divx (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (n),
      .dv_i   (dvx),
      .d_i    (d),
      .off_o  (offx[m])
    );

    isocc_divpipe u_divy (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (n),
      .dv_i   (dvy),
      .d_i    (d),
      .off_o  (offy[m])
    );
  end

  side_t sb_q [DivLat];
  logic [DivLat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivLat-2:0], s0_vld_q};
    end
  end

  for (genvar k = 0; k < DivLat; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sb_q[k] <= side_d;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sb_q[k] <= sb_q[k-1];
        end
      end
    end
  end

  side_t fin;
  logic [Corners-1:0][CoordW-1:0] p0x_d, p0y_d, p1x_d, p1y_d;
  logic [CntW-1:0] cnt_d;

  assign fin     = sb_q[DivLat-1];
  assign fin_vld = vld_q[DivLat-1];

  for (genvar m = 0; m < Corners; m++) begin : g_fin
    localparam int unsigned E = (m + 1) % Corners;
    assign p0x_d[m] = fin.flat[m] ? fin.x[m] : CoordW'(fin.x[m] + offx[m][CoordW-1:0]);
    assign p0y_d[m] = fin.flat[m] ? fin.y[m] : CoordW'(fin.y[m] + offy[m][CoordW-1:0]);
    assign p1x_d[m] = fin.x[E];
    assign p1y_d[m] = fin.y[E];
  end

  always_comb begin
    cnt_d = '0;
    for (int m = 0; m < Corners; m++) begin
      if (fin.hit[m]) begin
        cnt_d = cnt_d + (fin.flat[m] ? CntW'(2) : CntW'(1));
      end
    end
  end

  logic rec_vld_q, rec_vld_d;
  logic [Corners-1:0][CoordW-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
  logic [Corners-1:0] hit_q, flat_q;
  logic strip_q, sub_q, sub_d;
  logic [1:0] edge_q, edge_d, next_edge, first_edge;
  logic more_edge;

  always_comb begin
    next_edge = edge_q;
    more_edge = 1'b0;
    for (int m = Corners - 1; m >= 0; m--) begin
      if (hit_q[m] && 2'(m) > edge_q) begin
        next_edge = 2'(m);
        more_edge = 1'b1;
      end
    end
    first_edge = '0;
    for (int m = Corners - 1; m >= 0; m--) begin
      if (fin.hit[m]) begin
        first_edge = 2'(m);
      end
    end
  end

  assign cur_last = !(flat_q[edge_q] && !sub_q) && !more_edge;
  assign out_acc  = rec_vld_q && !out_stall_i;
  assign ser_free = !rec_vld_q || (out_acc && cur_last);
  assign adv      = !fin_vld || ser_free;

  always_comb begin
    rec_vld_d = rec_vld_q;
    edge_d    = edge_q;
    sub_d     = sub_q;
    if (out_acc) begin
      if (cur_last) begin
        rec_vld_d = 1'b0;
      end else if (flat_q[edge_q] && !sub_q) begin
        sub_d = 1'b1;
      end else begin
        edge_d = next_edge;
        sub_d  = 1'b0;
      end
    end
    if (ser_free && fin_vld && cnt_d >= CntW'(2)) begin
      rec_vld_d = 1'b1;
      edge_d    = first_edge;
      sub_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
      edge_q    <= '0;
      sub_q     <= 1'b0;
    end else begin
      rec_vld_q <= rec_vld_d;
      edge_q    <= edge_d;
      sub_q     <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free && fin_vld) begin
      p0x_q   <= p0x_d;
      p0y_q   <= p0y_d;
      p1x_q   <= p1x_d;
      p1y_q   <= p1y_d;
      hit_q   <= fin.hit;
      flat_q  <= fin.flat;
      strip_q <= cnt_d > CntW'(2);
    end
  end

  assign out_valid_o             = rec_vld_q;
  assign out_word_o.point_x      = sub_q ? p1x_q[edge_q] : p0x_q[edge_q];
  assign out_word_o.point_y      = sub_q ? p1y_q[edge_q] : p0y_q[edge_q];
  assign out_word_o.run_is_strip = strip_q;
  assign out_word_o.last_point   = cur_last;

endmodule
